// ----- design/gf2_poly_mult_mod_unit_defines.svh -----
// ----------------------------------------------------------------------------
// gf2_poly_mult_mod_unit_defines.svh
// Assertion macros shared by the GF(2) multiply-and-reduce unit.
// ----------------------------------------------------------------------------
`ifndef GF2_POLY_MULT_MOD_UNIT_DEFINES_SVH
`define GF2_POLY_MULT_MOD_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GF2PM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define GF2PM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/gf2pm_pkg.sv -----
// ----------------------------------------------------------------------------
// gf2pm_pkg
// Widths, command codes, state and control types of the GF(2) multiplier.
// ----------------------------------------------------------------------------
package gf2pm_pkg;

	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = 8;
	localparam int TOTAL_BITS = WORD_BITS * NUM_WORDS;
	localparam int IDX_W      = 3;
	localparam int WSH_W      = $clog2(WORD_BITS);
	localparam int CNT_W      = $clog2(TOTAL_BITS);
	localparam int DEG_W      = 9;

	localparam logic [DEG_W-1:0] DEG_MIN   = DEG_W'(2);
	localparam logic [DEG_W-1:0] DEG_MAX   = DEG_W'(TOTAL_BITS);
	localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(256);

	typedef enum logic [1:0] {
		FUNC_LOAD_A  = 2'd0,
		FUNC_LOAD_B  = 2'd1,
		FUNC_LOAD_R  = 2'd2,
		FUNC_COMPUTE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDB,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             init;
		logic             red_step;
		logic             mul_step;
		logic             out_step;
		logic [IDX_W-1:0] out_idx;
		logic             out_last;
	} ctl_t;

	// clamp the programmed degree into the supported range
	function automatic logic [DEG_W-1:0] clamp_degree(input logic [DEG_W-1:0] m);
		logic [DEG_W-1:0] r;
		r = m;
		if (m < DEG_MIN) begin
			r = DEG_MIN;
		end else if (m > DEG_MAX) begin
			r = DEG_MAX;
		end
		return r;
	endfunction

endpackage

// ----- design/gf2_poly_mult_mod_unit.sv -----
// ----------------------------------------------------------------------------
// gf2_poly_mult_mod_unit
// Multiply two binary polynomials and reduce modulo f = x^m + r over GF(2).
// ----------------------------------------------------------------------------
// A beat is taken whenever start is high and busy is low. Load beats (func 0,
// 1, 2) write one 32-bit word of a, b or r in that cycle and leave busy low.
// A compute beat (func 3) raises busy: one pass over all 256 bits reduces b
// modulo f one coefficient per cycle, a second pass over all 256 bits runs
// the MSB-first product over the bits of a through the same shift-and-fold
// logic, then the remainder is shifted out one result word at a time,
// ceil(m/32) words in all. Both passes run at one bit a cycle whatever m is.
// Result words are registered and appear in the cycle after each shift step,
// least significant first, each for exactly one cycle with result_valid high
// and last high on the final word. There is no back-pressure: the receiver
// must take every result beat as it comes. The degree register is written
// through cfg_we and cfg_wdata; the user must write it only while busy is
// low, as the block does not enforce it. Values below 2 act as 2, above 256 as 256.
// ----------------------------------------------------------------------------
`include "gf2_poly_mult_mod_unit_defines.svh"

module gf2_poly_mult_mod_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [gf2pm_pkg::IDX_W-1:0]     word_index,
	input  logic [gf2pm_pkg::WORD_BITS-1:0] word_data,
	input  logic                            cfg_we,
	input  logic [gf2pm_pkg::DEG_W-1:0]     cfg_wdata,
	output logic                            result_valid,
	output logic [gf2pm_pkg::IDX_W-1:0]     result_index,
	output logic [gf2pm_pkg::WORD_BITS-1:0] result_data,
	output logic                            last
);
	import gf2pm_pkg::*;

	logic [DEG_W-1:0]      modulus_degree_q;
	logic [DEG_W-1:0]      m_eff;
	ctl_t                  ctl;
	logic                  a_msb;
	logic                  b_msb;
	logic [TOTAL_BITS-1:0] r_poly;
	logic [WORD_BITS-1:0]  acc_word;

	logic                  res_valid_q;
	logic [IDX_W-1:0]      res_index_q;
	logic [WORD_BITS-1:0]  res_data_q;
	logic                  res_last_q;

	// degree register; the clamp keeps m inside the datapath width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_degree_q <= DEG_RESET;
		end else if (cfg_we) begin
			modulus_degree_q <= cfg_wdata;
		end
	end

	assign m_eff = clamp_degree(modulus_degree_q);

	gf2pm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.m_eff  (m_eff),
		.ctl    (ctl),
		.busy   (busy)
	);

	gf2pm_opnd u_opnd (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.func       (func),
		.word_index (word_index),
		.word_data  (word_data),
		.a_msb      (a_msb),
		.b_msb      (b_msb),
		.r_poly     (r_poly)
	);

	gf2pm_dp u_dp (
		.clk      (clk),
		.ctl      (ctl),
		.m_eff    (m_eff),
		.a_msb    (a_msb),
		.b_msb    (b_msb),
		.r_poly   (r_poly),
		.acc_word (acc_word)
	);

	// result register: one beat per word, strobe held for a single cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			res_valid_q <= ctl.out_step;
			res_last_q  <= ctl.out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_step) begin
			res_index_q <= ctl.out_idx;
			res_data_q  <= acc_word;
		end
	end

	assign result_valid = res_valid_q;
	assign result_index = res_index_q;
	assign result_data  = res_data_q;
	assign last         = res_last_q;

	// a compute beat always starts a run
	`GF2PM_ASSERT_NXT(a_cmp_busy, start && !busy && func == FUNC_COMPUTE, busy, "compute beat did not raise busy")
	// words of one run come back to back in index order
	`GF2PM_ASSERT_NXT(a_word_seq, result_valid && !last, result_valid && result_index == $past(result_index) + IDX_W'(1), "result words not consecutive")
	// while words remain, no new item may be taken
	`GF2PM_ASSERT_IMP(a_busy_out, result_valid && !last, busy, "busy dropped before the last word")

endmodule

// ----- design/gf2pm_opnd.sv -----
// ----------------------------------------------------------------------------
// gf2pm_opnd
// Operand store for a, b and r; a and b rotate one bit per step.
// ----------------------------------------------------------------------------
module gf2pm_opnd (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gf2pm_pkg::ctl_t              ctl,
	input  logic [1:0]                   func,
	input  logic [gf2pm_pkg::IDX_W-1:0]  word_index,
	input  logic [gf2pm_pkg::WORD_BITS-1:0] word_data,
	output logic                         a_msb,
	output logic                         b_msb,
	output logic [gf2pm_pkg::TOTAL_BITS-1:0] r_poly
);
	import gf2pm_pkg::*;

	logic [TOTAL_BITS-1:0] a_q;
	logic [TOTAL_BITS-1:0] b_q;
	logic [TOTAL_BITS-1:0] r_q;
	logic [CNT_W-1:0]      base;

	assign base = {word_index, {WSH_W{1'b0}}};

	// a full rotation over a pass leaves each operand as loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			r_q <= '0;
		end else if (ctl.load) begin
			unique case (func)
				FUNC_LOAD_A:  a_q[base +: WORD_BITS] <= word_data;
				FUNC_LOAD_B:  b_q[base +: WORD_BITS] <= word_data;
				FUNC_LOAD_R:  r_q[base +: WORD_BITS] <= word_data;
				FUNC_COMPUTE: ;
			endcase
		end else begin
			if (ctl.red_step) begin
				b_q <= {b_q[TOTAL_BITS-2:0], b_q[TOTAL_BITS-1]};
			end
			if (ctl.mul_step) begin
				a_q <= {a_q[TOTAL_BITS-2:0], a_q[TOTAL_BITS-1]};
			end
		end
	end

	assign a_msb  = a_q[TOTAL_BITS-1];
	assign b_msb  = b_q[TOTAL_BITS-1];
	assign r_poly = r_q;

endmodule

// ----- design/gf2pm_dp.sv -----
// ----------------------------------------------------------------------------
// gf2pm_dp
// Shift-and-fold datapath: reduces b, then runs the MSB-first product.
// ----------------------------------------------------------------------------
module gf2pm_dp (
	input  logic                             clk,
	input  gf2pm_pkg::ctl_t                  ctl,
	input  logic [gf2pm_pkg::DEG_W-1:0]      m_eff,
	input  logic                             a_msb,
	input  logic                             b_msb,
	input  logic [gf2pm_pkg::TOTAL_BITS-1:0] r_poly,
	output logic [gf2pm_pkg::WORD_BITS-1:0]  acc_word
);
	import gf2pm_pkg::*;

	logic [TOTAL_BITS-1:0] mask_d;
	logic [TOTAL_BITS-1:0] mask_q;
	logic [TOTAL_BITS-1:0] top_w;
	logic [TOTAL_BITS-1:0] rmask_w;
	logic [TOTAL_BITS-1:0] bred_q;
	logic [TOTAL_BITS-1:0] acc_q;
	logic [TOTAL_BITS-1:0] bred_x;
	logic [TOTAL_BITS-1:0] acc_x;

	for (genvar i = 0; i < TOTAL_BITS; i++) begin : g_mask
		assign mask_d[i] = (m_eff > DEG_W'(i));
	end

	// single bit at degree m-1; r limited to degree below m
	assign top_w   = mask_q & ~(mask_q >> 1);
	assign rmask_w = r_poly & mask_q;

	// v * x mod f, for v of degree below m
	function automatic logic [TOTAL_BITS-1:0] mul_x(
		input logic [TOTAL_BITS-1:0] v,
		input logic [TOTAL_BITS-1:0] msk,
		input logic [TOTAL_BITS-1:0] top,
		input logic [TOTAL_BITS-1:0] rm
	);
		logic ovf;
		ovf = |(v & top);
		return ((v << 1) & msk) ^ ({TOTAL_BITS{ovf}} & rm);
	endfunction

	assign bred_x = mul_x(bred_q, mask_q, top_w, rmask_w);
	assign acc_x  = mul_x(acc_q, mask_q, top_w, rmask_w);

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			mask_q <= mask_d;
			bred_q <= '0;
			acc_q  <= '0;
		end else if (ctl.red_step) begin
			bred_q <= bred_x ^ {{(TOTAL_BITS-1){1'b0}}, b_msb};
		end else if (ctl.mul_step) begin
			acc_q <= acc_x ^ (bred_q & {TOTAL_BITS{a_msb}});
		end else if (ctl.out_step) begin
			acc_q <= acc_q >> WORD_BITS;
		end
	end

	assign acc_word = acc_q[WORD_BITS-1:0];

endmodule

// ----- design/gf2pm_ctrl.sv -----
// ----------------------------------------------------------------------------
// gf2pm_ctrl
// Sequencer: b reduction pass, multiply pass, then result word beats.
// ----------------------------------------------------------------------------
module gf2pm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  func,
	input  logic [gf2pm_pkg::DEG_W-1:0] m_eff,
	output gf2pm_pkg::ctl_t             ctl,
	output logic                        busy
);
	import gf2pm_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] last_q;
	logic [DEG_W-1:0] m_less1;
	logic             idle;
	logic             acc_cmp;
	logic             cnt_end;
	logic             out_end;

	assign idle    = (state_q == ST_IDLE);
	assign acc_cmp = start && idle && (func == FUNC_COMPUTE);
	assign cnt_end = (cnt_q == {CNT_W{1'b1}});
	assign out_end = (cnt_q[IDX_W-1:0] == last_q);
	assign m_less1 = m_eff - DEG_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_cmp) state_d = ST_REDB;
			ST_REDB: if (cnt_end) state_d = ST_MUL;
			ST_MUL:  if (cnt_end) state_d = ST_OUT;
			ST_OUT:  if (out_end) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.load     = start && idle && (func != FUNC_COMPUTE);
		ctl.init     = acc_cmp;
		ctl.red_step = (state_q == ST_REDB);
		ctl.mul_step = (state_q == ST_MUL);
		ctl.out_step = (state_q == ST_OUT);
		ctl.out_idx  = cnt_q[IDX_W-1:0];
		ctl.out_last = (state_q == ST_OUT) && out_end;
		busy         = !idle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (idle) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (acc_cmp) begin
				last_q <= m_less1[CNT_W-1:WSH_W];
			end
		end
	end

endmodule
